@@ hdl/mec_pkg.sv @@
// ----------------------------------------------------------------------------
// mec_pkg
// Shared constants and types for the motion event confirmer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    localparam int MAX_TRIGGERS  = 8;
    localparam int CNT_W         = $clog2(MAX_TRIGGERS + 1);
    localparam int TIME_W        = 32;
    localparam int WIN_W         = 16;
    localparam int MIN_W         = 4;
    localparam int SEC_W         = 16;
    localparam int MS_PER_SECOND = 1000;
    // 65535 s * 1000 fits in 26 bits
    localparam int COOL_MS_W     = 26;
    localparam int CMP_W         = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW   = 2'd0,
        CFG_MIN      = 2'd1,
        CFG_COOLDOWN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [WIN_W-1:0]     window_ms;
        logic [MIN_W-1:0]     min_events;
        logic [COOL_MS_W-1:0] cooldown_ms;
    } t_cfg;

endpackage

`default_nettype wire

@@ hdl/mec_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mec_cfg_regs
// Configuration registers; cooldown is kept pre-scaled to milliseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mec_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mec_pkg::t_cfg                       o_cfg
);
    import mec_pkg::*;

    localparam int MUL_W = SEC_W + 10;

    t_cfg             r_cfg;
    logic [MUL_W-1:0] w_cool_ms;

    assign w_cool_ms = MUL_W'(i_cfg_data[SEC_W-1:0]) * MUL_W'(MS_PER_SECOND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW:   r_cfg.window_ms   <= i_cfg_data[WIN_W-1:0];
                CFG_MIN:      r_cfg.min_events  <= i_cfg_data[MIN_W-1:0];
                CFG_COOLDOWN: r_cfg.cooldown_ms <= w_cool_ms[COOL_MS_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/mec_engine.sv @@
// ----------------------------------------------------------------------------
// mec_engine
// Trigger store, window count, cooldown; updates state once per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mec_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic                       i_level,
    input  wire logic [mec_pkg::TIME_W-1:0] i_time,
    input  wire mec_pkg::t_cfg              i_cfg,
    output logic                            o_confirm
);
    import mec_pkg::*;

    logic [TIME_W-1:0]       r_times [MAX_TRIGGERS];
    logic [CNT_W-1:0]        r_count;
    logic                    r_prev;
    logic [TIME_W-1:0]       r_cool_end;

    logic [TIME_W-1:0]       w_times [MAX_TRIGGERS];
    logic [CNT_W-1:0]        w_cnt;
    logic                    w_edge;
    logic                    w_full;
    logic [MAX_TRIGGERS-1:0] w_hit;
    logic [CNT_W-1:0]        w_hits;
    logic                    w_in_cool;

    assign w_edge = i_level && !r_prev;
    assign w_full = (r_count == CNT_W'(MAX_TRIGGERS));
    assign w_cnt  = (w_edge && !w_full) ? r_count + CNT_W'(1) : r_count;

    // Store after this beat's trigger: append, or drop oldest and shift down
    for (genvar g = 0; g < MAX_TRIGGERS; g++) begin : g_slot
        logic [TIME_W-1:0] w_up;
        logic [TIME_W-1:0] w_age;
        if (g < MAX_TRIGGERS - 1) begin : g_mid
            assign w_up = r_times[g+1];
        end else begin : g_top
            assign w_up = i_time;
        end
        always_comb begin
            if (w_edge && w_full) begin
                w_times[g] = w_up;
            end else if (w_edge && (r_count == CNT_W'(g))) begin
                w_times[g] = i_time;
            end else begin
                w_times[g] = r_times[g];
            end
        end
        assign w_age    = i_time - w_times[g];
        assign w_hit[g] = (CNT_W'(g) < w_cnt) &&
                          (w_age <= TIME_W'(i_cfg.window_ms));
    end

    assign w_hits    = CNT_W'($countones(w_hit));
    assign w_in_cool = (i_time < r_cool_end);
    assign o_confirm = !w_in_cool && (CMP_W'(w_hits) >= CMP_W'(i_cfg.min_events));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_prev     <= 1'b0;
            r_cool_end <= '0;
        end else if (i_fire) begin
            r_prev  <= i_level;
            r_count <= o_confirm ? '0 : w_cnt;
            if (o_confirm) begin
                r_cool_end <= i_time + TIME_W'(i_cfg.cooldown_ms);
            end
        end
    end

    // Entries above the fill count are never read
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_times <= w_times;
        end
    end

endmodule

`default_nettype wire

@@ hdl/motion_event_confirmer_core.sv @@
// ----------------------------------------------------------------------------
// motion_event_confirmer_core
// K-of-N motion trigger confirmation with cooldown, valid/ready streaming.
// ----------------------------------------------------------------------------
// Path: input beat -> input register -> engine (combinational) -> result register.
// Throughput: one beat per cycle while the result register is empty or being taken;
//   the store/cooldown update is done in the engine stage between the two registers.
// Reset: synchronous active low; clears handshake state, fill count, previous
//   level, cooldown end and configuration. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module motion_event_confirmer_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_raw_level,
    input  wire logic [mec_pkg::TIME_W-1:0]     i_time_ms,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_confirmed
);
    import mec_pkg::*;

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    logic              r_out_confirmed;
    logic              w_fire;
    logic              w_confirm;

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    // no beat is taken while reset is held
    assign o_ready = i_rst_n && (!r_in_valid || w_fire);

    mec_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mec_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_level   (r_in_level),
        .i_time    (r_in_time),
        .i_cfg     (w_cfg),
        .o_confirm (w_confirm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_level <= i_raw_level;
            r_in_time  <= i_time_ms;
        end
        if (w_fire) begin
            r_out_confirmed <= w_confirm;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_confirmed = r_out_confirmed;

endmodule

`default_nettype wire
